// ===== design/svc_pkg.sv =====
`default_nettype none

package svc_pkg;

  localparam int RootW = 17;
  localparam int RemW  = 33;
  localparam int NumW  = 49;
  localparam int DenW  = 33;

  typedef logic signed [19:0] sq_t;

  typedef enum logic [1:0] {
    STYLE_BEZIER = 2'b00,
    STYLE_SPIRAL = 2'b01,
    STYLE_GRAY   = 2'b10
  } style_e;

  typedef enum logic {
    CFG_PATH_STYLE = 1'b0,
    CFG_TURN_COUNT = 1'b1
  } cfg_idx_e;

  localparam logic [16:0] Q16_ONE  = 17'd65536;
  localparam sq_t         ONE_S    = 20'sd65536;
  localparam sq_t         HALF_S   = 20'sd32768;

  localparam logic [30:0] POLY_C0 = 31'd172272;
  localparam logic [30:0] POLY_C1 = 31'd5026995;
  localparam logic [30:0] POLY_C2 = 31'd85569306;
  localparam logic [30:0] POLY_C3 = 31'd693598668;
  localparam logic [30:0] POLY_C4 = 31'd1686629713;

  localparam logic [DenW-1:0] KSPR_EPS = 33'd42949673;

  localparam sq_t         SPR_BASE  = 20'sd36045;
  localparam sq_t         SPR_AMP   = 20'sd29491;
  localparam sq_t         WHT_OFS   = 20'sd2182;
  localparam logic [31:0] WHT_SLOPE = 32'd21850;

  localparam logic [16:0] BEZ_MIN [3] = '{17'd32768, 17'd32768, 17'd32768};
  localparam logic [16:0] BEZ_MED [3] = '{17'd65536, 17'd21823, 17'd0};
  localparam logic [16:0] BEZ_MAX [3] = '{17'd65536, 17'd61145, 17'd58982};
  localparam sq_t DIR_U   [3] = '{20'sd32768, -20'sd16384, 20'sd0};
  localparam sq_t DIR_V   [3] = '{20'sd0, 20'sd5459, -20'sd32768};
  localparam sq_t DIR_SUM [3] = '{20'sd32768, -20'sd10925, -20'sd32768};

  typedef struct packed {
    logic                neg;
    logic                zero;
    logic [16:0]         ah;
    logic signed [17:0]  sn;
    logic signed [17:0]  cs;
    logic [RemW-1:0]     sq_rem;
    logic [RootW-1:0]    root;
    logic [NumW-1:0]     dv_rem;
    logic [DenW-1:0]     den;
    logic [RootW-1:0]    quo;
  } chain_t;

  // Q16 product, rounded half away from zero.
  function automatic sq_t mulq(sq_t x, sq_t y);
    logic        neg;
    logic [19:0] ux;
    logic [19:0] uy;
    logic [39:0] p;
    logic [39:0] r;
    neg = x[19] ^ y[19];
    ux  = x[19] ? 20'(-x) : 20'(x);
    uy  = y[19] ? 20'(-y) : 20'(y);
    p   = {20'b0, ux} * {20'b0, uy};
    r   = (p + 40'd32768) >> 16;
    return neg ? -sq_t'(r[19:0]) : sq_t'(r[19:0]);
  endfunction

  // (a * ka + b * kb + 0.5) in Q16 for nonnegative operands.
  function automatic logic [16:0] bez_mix(logic [16:0] a, logic [16:0] ka,
                                          logic [16:0] b, logic [16:0] kb);
    logic [33:0] p;
    p = {17'b0, a} * {17'b0, ka} + {17'b0, b} * {17'b0, kb} + 34'd32768;
    return p[32:16];
  endfunction

endpackage

`default_nettype wire

// ===== design/svc_front.sv =====
`default_nettype none

module svc_front import svc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] sample_i,
  input  logic signed [7:0]  turn_count_i,
  output logic               valid_o,
  output chain_t             data_o
);

  localparam int NS = 7;

  typedef struct packed {
    logic        neg;
    logic        zero;
    logic [14:0] mag;
    logic [1:0]  quad;
    logic [16:0] us;
    logic [16:0] uc;
  } carry_t;

  logic [NS-1:0]      vld_q;
  carry_t             car_q [NS];
  carry_t             car_d;
  logic [16:0]        x2_q [1:4][2];
  logic [30:0]        tp_q [2:5][2];
  logic [32:0]        h2_q;
  logic [NumW-1:0]    num_q [2:6];
  logic [DenW-1:0]    den_q [2:6];
  logic signed [17:0] sn_q;
  logic signed [17:0] cs_q;
  logic signed [17:0] sn_d;
  logic signed [17:0] cs_d;

  logic signed [15:0] clip;
  logic [14:0]        mag;
  logic [21:0]        phase;
  logic [16:0]        ah1;
  logic [33:0]        h2_full;
  logic [DenW-1:0]    den_d;
  logic [NumW-1:0]    num_d;
  logic [47:0]        sp [2];
  logic [16:0]        sin_d [2];
  logic signed [17:0] s_val;
  logic signed [17:0] c_val;

  function automatic logic [16:0] sq_q16(logic [16:0] u);
    logic [33:0] p;
    p = {17'b0, u} * {17'b0, u};
    return p[32:16];
  endfunction

  function automatic logic [30:0] poly_step(logic [30:0] c, logic [16:0] x2,
                                            logic [30:0] t);
    logic [47:0] p;
    p = {31'b0, x2} * {17'b0, t};
    return c - p[46:16];
  endfunction

  always_comb begin
    if (sample_i > 16'sd16384) begin
      clip = 16'sd16384;
    end else if (sample_i < -16'sd16384) begin
      clip = -16'sd16384;
    end else begin
      clip = sample_i;
    end
    mag   = clip[15] ? 15'(-clip) : 15'(clip);
    phase = {8'b0, mag[13:0]} * {{14{turn_count_i[7]}}, turn_count_i};
    car_d.neg  = clip[15];
    car_d.zero = (mag == '0);
    car_d.mag  = mag;
    car_d.quad = phase[13:12];
    car_d.us   = {1'b0, phase[11:0], 4'b0};
    car_d.uc   = Q16_ONE - {1'b0, phase[11:0], 4'b0};
  end

  assign ah1     = {car_q[0].mag, 2'b0};
  assign h2_full = {17'b0, ah1} * {17'b0, ah1};
  assign den_d   = h2_q + KSPR_EPS;
  assign num_d   = {h2_q, 16'b0} + NumW'(den_d >> 1);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sp[l] = {31'b0, (l == 0) ? car_q[5].us : car_q[5].uc} * {17'b0, tp_q[5][l]};
      sin_d[l] = (sp[l][47:30] > 18'd65536) ? Q16_ONE : sp[l][46:30];
    end
    s_val = signed'({1'b0, sin_d[0]});
    c_val = signed'({1'b0, sin_d[1]});
    sn_d  = car_q[5].quad[0] ? c_val : s_val;
    cs_d  = car_q[5].quad[0] ? s_val : c_val;
    if (car_q[5].quad[1]) begin
      sn_d = -sn_d;
    end
    if (car_q[5].quad[1] ^ car_q[5].quad[0]) begin
      cs_d = -cs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      car_q[0] <= car_d;
      for (int k = 1; k < NS; k++) begin
        car_q[k] <= car_q[k-1];
      end
      for (int l = 0; l < 2; l++) begin
        x2_q[1][l] <= sq_q16((l == 0) ? car_q[0].us : car_q[0].uc);
        x2_q[2][l] <= x2_q[1][l];
        x2_q[3][l] <= x2_q[2][l];
        x2_q[4][l] <= x2_q[3][l];
        tp_q[2][l] <= poly_step(POLY_C1, x2_q[1][l], POLY_C0);
        tp_q[3][l] <= poly_step(POLY_C2, x2_q[2][l], tp_q[2][l]);
        tp_q[4][l] <= poly_step(POLY_C3, x2_q[3][l], tp_q[3][l]);
        tp_q[5][l] <= poly_step(POLY_C4, x2_q[4][l], tp_q[4][l]);
      end
      h2_q     <= h2_full[32:0];
      num_q[2] <= num_d;
      den_q[2] <= den_d;
      for (int k = 3; k <= 6; k++) begin
        num_q[k] <= num_q[k-1];
        den_q[k] <= den_q[k-1];
      end
      sn_q <= sn_d;
      cs_q <= cs_d;
    end
  end

  assign valid_o = vld_q[NS-1];

  always_comb begin
    data_o.neg    = car_q[6].neg;
    data_o.zero   = car_q[6].zero;
    data_o.ah     = {car_q[6].mag, 2'b0};
    data_o.sn     = sn_q;
    data_o.cs     = cs_q;
    data_o.sq_rem = {car_q[6].mag, 18'b0};
    data_o.root   = '0;
    data_o.dv_rem = num_q[6];
    data_o.den    = den_q[6];
    data_o.quo    = '0;
  end

endmodule

`default_nettype wire

// ===== design/svc_cell.sv =====
`default_nettype none

module svc_cell import svc_pkg::*; #(
  parameter int BitIdx = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  chain_t data_i,
  output logic   valid_o,
  output chain_t data_o
);

  localparam int TrialW = RemW + 2;

  logic [TrialW-1:0] trial;
  logic [NumW-1:0]   dsub;
  chain_t            data_d;
  chain_t            data_q;
  logic              valid_q;

  // One root bit of the square root and one quotient bit of the blend weight.
  always_comb begin
    data_d = data_i;
    trial  = ({{(TrialW-RootW){1'b0}}, data_i.root} << (BitIdx + 1))
           + (TrialW'(1) << (2 * BitIdx));
    if ({{(TrialW-RemW){1'b0}}, data_i.sq_rem} >= trial) begin
      data_d.sq_rem = data_i.sq_rem - trial[RemW-1:0];
      data_d.root   = data_i.root | (RootW'(1) << BitIdx);
    end
    dsub = {{(NumW-DenW){1'b0}}, data_i.den} << BitIdx;
    if (data_i.dv_rem >= dsub) begin
      data_d.dv_rem = data_i.dv_rem - dsub;
      data_d.quo    = data_i.quo | (RootW'(1) << BitIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/svc_back.sv =====
`default_nettype none

module svc_back import svc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  chain_t            data_i,
  input  logic [1:0]        path_style_i,
  input  logic signed [7:0] turn_count_i,
  output logic              valid_o,
  output logic [15:0]       red_o,
  output logic [15:0]       green_o,
  output logic [15:0]       blue_o,
  output logic              bad_setup_o
);

  localparam int NS = 4;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] neg_q;
  logic [NS-1:0] zero_q;

  logic [16:0] ah1_q;
  sq_t         au1_q;
  sq_t         av1_q;
  sq_t         qwht1_q;
  logic [16:0] kspr1_q;
  logic [16:0] kspr2_q;
  logic [16:0] kspr3_q;
  logic [16:0] t1_q;
  logic [16:0] s1_q;
  logic [16:0] v0_q [3];
  logic [16:0] v1_q [3];

  sq_t         e2_q [3];
  sq_t         qwht2_q;
  sq_t         qell2_q;
  sq_t         bc2_q [3];
  sq_t         bc3_q [3];
  logic [16:0] col0_2_q [3];
  logic [16:0] col0_3_q [3];
  sq_t         ac3_q [3];
  sq_t         col4_q [3];

  sq_t         au_d;
  sq_t         av_d;
  sq_t         qwht_d;
  logic [31:0] wp;
  logic [16:0] t_d;
  logic [16:0] s_d;
  sq_t         kspr_s;
  sq_t         v_fin [3];
  logic [16:0] cl [3];
  logic [32:0] op [3];
  logic [15:0] o [3];
  logic        bad;

  assign t_d = data_i.root;
  assign s_d = Q16_ONE - data_i.root;
  assign wp  = WHT_SLOPE * {15'b0, data_i.ah} + 32'd32768;

  always_comb begin
    if (path_style_i == STYLE_SPIRAL) begin
      au_d = SPR_BASE + mulq(SPR_AMP, sq_t'(data_i.cs));
      av_d = SPR_BASE + mulq(SPR_AMP, sq_t'(data_i.sn));
    end else begin
      au_d = sq_t'(data_i.cs);
      av_d = sq_t'(data_i.sn);
    end
    qwht_d = WHT_OFS + sq_t'({4'b0, wp[31:16]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q  <= {neg_q[NS-2:0], data_i.neg};
      zero_q <= {zero_q[NS-2:0], data_i.zero};

      ah1_q   <= data_i.ah;
      au1_q   <= au_d;
      av1_q   <= av_d;
      qwht1_q <= qwht_d;
      kspr1_q <= data_i.quo;
      t1_q    <= t_d;
      s1_q    <= s_d;

      qwht2_q <= qwht1_q;
      qell2_q <= ONE_S - qwht1_q;
      kspr2_q <= kspr1_q;
      kspr3_q <= kspr2_q;

      for (int c = 0; c < 3; c++) begin
        v0_q[c] <= bez_mix(s_d, BEZ_MIN[c], t_d, BEZ_MED[c]);
        v1_q[c] <= bez_mix(s_d, BEZ_MED[c], t_d, BEZ_MAX[c]);

        e2_q[c] <= HALF_S + mulq(au1_q, DIR_U[c]) + mulq(av1_q, DIR_V[c]);
        if (path_style_i == STYLE_SPIRAL) begin
          bc2_q[c] <= mulq(sq_t'({3'b0, Q16_ONE - ah1_q}), HALF_S)
                    + mulq(sq_t'({3'b0, ah1_q}), DIR_SUM[c]);
        end else begin
          bc2_q[c] <= HALF_S;
        end
        col0_2_q[c] <= bez_mix(s1_q, v0_q[c], t1_q, v1_q[c]);

        ac3_q[c]    <= qwht2_q + mulq(qell2_q, e2_q[c]);
        bc3_q[c]    <= bc2_q[c];
        col0_3_q[c] <= col0_2_q[c];

        if (path_style_i == STYLE_BEZIER) begin
          col4_q[c] <= sq_t'({3'b0, col0_3_q[c]});
        end else begin
          col4_q[c] <= mulq(kspr_s, ac3_q[c]) + mulq(ONE_S - kspr_s, bc3_q[c]);
        end
      end
    end
  end

  assign kspr_s = sq_t'({3'b0, kspr3_q});

  assign bad = !((path_style_i == STYLE_BEZIER && turn_count_i == 8'sd1)
              || path_style_i == STYLE_SPIRAL || path_style_i == STYLE_GRAY);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (zero_q[NS-1]) begin
        v_fin[c] = HALF_S;
      end else if (neg_q[NS-1]) begin
        v_fin[c] = ONE_S - col4_q[c];
      end else begin
        v_fin[c] = col4_q[c];
      end
      if (v_fin[c] < 0) begin
        cl[c] = '0;
      end else if (v_fin[c] > ONE_S) begin
        cl[c] = Q16_ONE;
      end else begin
        cl[c] = v_fin[c][16:0];
      end
      op[c] = {16'b0, cl[c]} * 33'd65535 + 33'd32768;
      o[c]  = bad ? 16'd0 : op[c][31:16];
    end
  end

  assign valid_o     = vld_q[NS-1];
  assign red_o       = o[0];
  assign green_o     = o[1];
  assign blue_o      = o[2];
  assign bad_setup_o = bad;

endmodule

`default_nettype wire

// ===== design/signed_value_colormap_unit.sv =====
// Pipeline: a word accepted at the input passes 29 register stages on its way to the output
// (7 front, 17 chain cells, 4 back, 1 output register).
// Throughput: one word per clock; the whole pipeline holds while an output word waits.
// The chain of 17 cells produces one square root bit and one blend weight bit per stage.
// Reset clears all valid flags and loads path_style = 1 and turn_count = 1.
`default_nettype none

module signed_value_colormap_unit import svc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        red_o,
  output logic [15:0]        green_o,
  output logic [15:0]        blue_o,
  output logic               bad_setup_o
);

  localparam int NCell = RootW;

  logic              adv;
  logic [1:0]        path_style_q;
  logic signed [7:0] turn_count_q;
  logic [NCell:0]    chain_vld;
  chain_t            chain_dat [NCell+1];
  logic              back_vld;
  logic [15:0]       back_r;
  logic [15:0]       back_g;
  logic [15:0]       back_b;
  logic              back_bad;
  logic              out_valid_q;
  logic [15:0]       red_q;
  logic [15:0]       green_q;
  logic [15:0]       blue_q;
  logic              bad_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_style_q <= STYLE_SPIRAL;
      turn_count_q <= 8'sd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PATH_STYLE: path_style_q <= cfg_data_i[1:0];
        CFG_TURN_COUNT: turn_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  svc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (in_valid_i),
    .sample_i     (sample_i),
    .turn_count_i (turn_count_q),
    .valid_o      (chain_vld[0]),
    .data_o       (chain_dat[0])
  );

  for (genvar j = 0; j < NCell; j++) begin : g_cell
    svc_cell #(
      .BitIdx (NCell - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_vld[j]),
      .data_i  (chain_dat[j]),
      .valid_o (chain_vld[j+1]),
      .data_o  (chain_dat[j+1])
    );
  end

  svc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .valid_i      (chain_vld[NCell]),
    .data_i       (chain_dat[NCell]),
    .path_style_i (path_style_q),
    .turn_count_i (turn_count_q),
    .valid_o      (back_vld),
    .red_o        (back_r),
    .green_o      (back_g),
    .blue_o       (back_b),
    .bad_setup_o  (back_bad)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= back_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= back_r;
      green_q <= back_g;
      blue_q  <= back_b;
      bad_q   <= back_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign bad_setup_o = bad_q;

  // The input is held off only while a finished word waits at the output.
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting output word");

  // While held, no word moves through the cell chain.
  a_chain_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(chain_vld))
    else $error("cell chain moved while held");

  // An unusable setup always comes with black.
  a_bad_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_setup_o |-> red_o == 16'd0 && green_o == 16'd0 && blue_o == 16'd0)
    else $error("bad setup word carries color");

endmodule

`default_nettype wire
